// File: rtl/salru_pkg.sv
// Shared types and fixed constants for the set-associative LRU cache lookup.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package salru_pkg;

   localparam int CNT_BITS      = 32;
   localparam int WAYS_LOG2_BITS = 3;
   localparam int WAY_USED_BITS = 4;
   localparam int KEY_MAX_BITS  = 16;
   localparam int SHIFT_BITS    = 4;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } salru_cmd_type;

   typedef struct packed {
      logic scan_done;
   } salru_status_type;

endpackage

`default_nettype wire

// File: rtl/salru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module salru_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/salru_ctrl.sv
// Controller state machine for the cache lookup: accept, scan the ways, commit.
// Depends on salru_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module salru_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   output salru_pkg::salru_cmd_type         cmd,
   input  wire salru_pkg::salru_status_type status
);

   import salru_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/salru_dp.sv
// Datapath of the cache lookup: layout register, tag/age RAM, valid bits,
// way scan with oldest-way search, counters and result registers.
// Depends on salru_pkg and salru_ram.
`timescale 1ns / 1ps
`default_nettype none

module salru_dp #(
   parameter int TOTAL_BLOCKS = 16,
   parameter int ADDRESS_BITS = 16,
   parameter int AGE_BITS     = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire salru_pkg::salru_cmd_type               cmd,
   output salru_pkg::salru_status_type                 status,
   input  wire logic                                   csr_valid,
   input  wire logic [salru_pkg::WAYS_LOG2_BITS-1:0]   csr_ways_log2,
   input  wire logic [ADDRESS_BITS-1:0]                req_address,
   output logic                                        rsp_valid,
   output logic                                        rsp_hit,
   output logic      [salru_pkg::WAY_USED_BITS-1:0]    rsp_way_used,
   output logic      [salru_pkg::CNT_BITS-1:0]         rsp_hit_total,
   output logic      [salru_pkg::CNT_BITS-1:0]         rsp_access_total
);

   import salru_pkg::*;

   localparam int IDX_W    = $clog2(TOTAL_BLOCKS);
   localparam int TB_LOG2  = $clog2(TOTAL_BLOCKS + 1) - 1;
   localparam int KEY_BITS = (ADDRESS_BITS < KEY_MAX_BITS) ? ADDRESS_BITS : KEY_MAX_BITS;
   localparam int RAM_W    = KEY_BITS + AGE_BITS;

   logic [WAYS_LOG2_BITS-1:0] ways_log2_ff;
   logic [AGE_BITS-1:0]       acc_num_ff;
   logic [CNT_BITS-1:0]       hits_ff;
   logic [CNT_BITS-1:0]       probes_ff;
   logic [TOTAL_BLOCKS-1:0]   valid_ff;
   logic                      rsp_valid_ff;

   logic [KEY_BITS-1:0]       key_ff;
   logic [IDX_W-1:0]          base_ff;
   logic [IDX_W-1:0]          way_ff;
   logic [IDX_W-1:0]          victim_ff;
   logic [AGE_BITS-1:0]       best_age_ff;
   logic [IDX_W:0]            examined_ff;
   logic                      hit_ff;

   logic                      rsp_hit_ff;
   logic [WAY_USED_BITS-1:0]  rsp_way_used_ff;
   logic [CNT_BITS-1:0]       rsp_hit_total_ff;
   logic [CNT_BITS-1:0]       rsp_access_total_ff;

   logic [SHIFT_BITS-1:0]     wl_eff;
   logic [SHIFT_BITS-1:0]     set_bits;
   logic [IDX_W-1:0]          set_mask;
   logic [IDX_W-1:0]          ways_m1;
   logic [KEY_BITS-1:0]       key_now;
   logic [IDX_W-1:0]          base_now;
   logic [IDX_W-1:0]          way_next;
   logic [IDX_W-1:0]          rd_addr;
   logic [IDX_W-1:0]          entry_cur;
   logic [IDX_W-1:0]          entry_victim;
   logic [RAM_W-1:0]          rd_data;
   logic [KEY_BITS-1:0]       rd_tag;
   logic [AGE_BITS-1:0]       rd_age;
   logic                      cur_valid;
   logic                      match;
   logic                      last_way;
   logic [CNT_BITS:0]         hits_sum;
   logic [CNT_BITS:0]         probes_sum;
   logic [CNT_BITS-1:0]       hits_in;
   logic [CNT_BITS-1:0]       probes_in;

   // layout: clamp ways to the block count, sets take the remaining index bits
   assign wl_eff   = ({1'b0, ways_log2_ff} > SHIFT_BITS'(TB_LOG2)) ?
                     SHIFT_BITS'(TB_LOG2) : {1'b0, ways_log2_ff};
   assign set_bits = SHIFT_BITS'(TB_LOG2) - wl_eff;
   assign set_mask = ~({IDX_W{1'b1}} << set_bits);
   assign ways_m1  = ~({IDX_W{1'b1}} << wl_eff);

   assign key_now  = KEY_BITS'(req_address);
   assign base_now = (IDX_W'(key_now) & set_mask) << wl_eff;
   assign way_next = (way_ff + IDX_W'(1)) & ways_m1;

   // fetch way 0 while idle, then the following way during each scan cycle
   assign rd_addr      = cmd.scan ? (base_ff + way_next) : base_now;
   assign entry_cur    = base_ff + way_ff;
   assign entry_victim = base_ff + victim_ff;

   salru_ram #(
      .WIDTH (RAM_W),
      .DEPTH (TOTAL_BLOCKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (entry_victim),
      .wr_data ({key_ff, acc_num_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_tag    = rd_data[RAM_W-1:AGE_BITS];
   assign rd_age    = rd_data[AGE_BITS-1:0];
   assign cur_valid = valid_ff[entry_cur];
   assign match     = cur_valid && (rd_tag == key_ff);
   assign last_way  = (way_ff == ways_m1);

   assign status.scan_done = match || !cur_valid || last_way;

   assign hits_sum   = {1'b0, hits_ff} + (CNT_BITS + 1)'(hit_ff);
   assign probes_sum = {1'b0, probes_ff} + (CNT_BITS + 1)'(examined_ff)
                       + (CNT_BITS + 1)'(!hit_ff);
   assign hits_in    = hits_sum[CNT_BITS] ? {CNT_BITS{1'b1}} : hits_sum[CNT_BITS-1:0];
   assign probes_in  = probes_sum[CNT_BITS] ? {CNT_BITS{1'b1}} : probes_sum[CNT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_log2_ff <= '0;
         acc_num_ff   <= '0;
         hits_ff      <= '0;
         probes_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            ways_log2_ff <= csr_ways_log2;
         end
         if (cmd.load) begin
            acc_num_ff <= acc_num_ff + AGE_BITS'(1);
         end
         if (cmd.commit) begin
            valid_ff[entry_victim] <= 1'b1;
            hits_ff                <= hits_in;
            probes_ff              <= probes_in;
         end
         rsp_valid_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff  <= key_now;
         base_ff <= base_now;
         way_ff  <= '0;
         hit_ff  <= 1'b0;
      end
      if (cmd.scan) begin
         way_ff      <= way_next;
         examined_ff <= {1'b0, way_ff} + (IDX_W + 1)'(1);
         priority if (match) begin
            hit_ff    <= 1'b1;
            victim_ff <= way_ff;
         end else if (!cur_valid) begin
            victim_ff <= way_ff;
         end else if ((way_ff == '0) || (rd_age < best_age_ff)) begin
            victim_ff   <= way_ff;
            best_age_ff <= rd_age;
         end
      end
      if (cmd.commit) begin
         rsp_hit_ff          <= hit_ff;
         rsp_way_used_ff     <= WAY_USED_BITS'(victim_ff);
         rsp_hit_total_ff    <= hits_in;
         rsp_access_total_ff <= probes_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_way_used     = rsp_way_used_ff;
   assign rsp_hit_total    = rsp_hit_total_ff;
   assign rsp_access_total = rsp_access_total_ff;

`ifndef NO_ASSERTIONS
   a_commit_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(cmd.scan && status.scan_done))
      else $error("commit without a finished scan");

   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.commit))
      else $error("result strobe without a commit");

   a_hit_on_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && hit_ff) |-> valid_ff[entry_victim])
      else $error("hit committed to an invalid entry");

   a_examined_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (examined_ff != '0))
      else $error("commit with no way examined");
`endif

endmodule

`default_nettype wire

// File: rtl/set_assoc_lru_cache_lookup_top.sv
// Top level of the set-associative LRU cache lookup: controller and datapath.
// Depends on salru_pkg, salru_ctrl, salru_dp (and salru_ram through the datapath).
//
// Each lookup accepts the address and fetches way 0, then compares the ways in turn
// until a hit, an invalid way or the last way, as the single tag/age RAM read port
// delivers one way a cycle, and then writes back tag, age and valid bit. busy is high
// in the scan and write-back states; the result strobe rsp_valid is high for one cycle
// just after the write-back, and the receiver cannot stall it, so a new item may be
// started in that same cycle. csr_ready is always high; write ways_log2 only while idle.
// No clearing pass: reset clears counters, ways_log2 and valid bits, not the RAM.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_lookup_top #(
   parameter int TOTAL_BLOCKS = 16,
   parameter int ADDRESS_BITS = 16,
   parameter int AGE_BITS     = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [ADDRESS_BITS-1:0]              req_address,
   output logic                                      rsp_valid,
   output logic                                      rsp_hit,
   output logic      [salru_pkg::WAY_USED_BITS-1:0]  rsp_way_used,
   output logic      [salru_pkg::CNT_BITS-1:0]       rsp_hit_total,
   output logic      [salru_pkg::CNT_BITS-1:0]       rsp_access_total,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [salru_pkg::WAYS_LOG2_BITS-1:0] csr_ways_log2
);

   import salru_pkg::*;

   salru_cmd_type    cmd;
   salru_status_type status;

   assign csr_ready = 1'b1;

   salru_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   salru_dp #(
      .TOTAL_BLOCKS (TOTAL_BLOCKS),
      .ADDRESS_BITS (ADDRESS_BITS),
      .AGE_BITS     (AGE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_ways_log2    (csr_ways_log2),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_way_used     (rsp_way_used),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_access_total (rsp_access_total)
   );

endmodule

`default_nettype wire
